// ===== hw/rtl/slle_pkg.sv =====
// shared types and constants for the cursor-linked list engine
// no dependencies; imported by every module of the block
`default_nettype none

package slle_pkg;

  // default node store size (node 0 is the list head)
  localparam int unsigned LIST_SIZE_DEF = 128;

  // payload field widths
  localparam int unsigned ACTION_W   = 1;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned STATUS_W   = 2;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_INSERT = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_LINK,
    S_WBACK,
    S_FINISH
  } seq_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slle_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read port
// uses slle_pkg for the LIST_SIZE_DEF and VALUE_W parameter defaults
`default_nettype none

module slle_ram
  import slle_pkg::*;
#(
  parameter int unsigned DEPTH = LIST_SIZE_DEF,
  parameter int unsigned WIDTH = VALUE_W
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/slle_seq.sv =====
// sequencer and datapath: clearing pass, list walk, relink and result register
// depends on slle_pkg; drives the link and value rams in the top level
`default_nettype none

module slle_seq
  import slle_pkg::*;
#(
  parameter int unsigned LIST_SIZE = LIST_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [ACTION_W-1:0]           in_action,
  input  wire logic [POS_W-1:0]              in_position,
  input  wire logic [VALUE_W-1:0]            in_value_in,
  // result channel
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [STATUS_W-1:0]           out_status,
  output      logic [VALUE_W-1:0]            out_removed_value,
  output      logic [POS_W-1:0]              out_list_length,
  // link ram
  output      logic                          link_we,
  output      logic [$clog2(LIST_SIZE)-1:0]  link_waddr,
  output      logic [$clog2(LIST_SIZE)-1:0]  link_wdata,
  output      logic [$clog2(LIST_SIZE)-1:0]  link_raddr,
  input  wire logic [$clog2(LIST_SIZE)-1:0]  link_rdata,
  // value ram
  output      logic                          val_we,
  output      logic [$clog2(LIST_SIZE)-1:0]  val_waddr,
  output      logic [VALUE_W-1:0]            val_wdata,
  output      logic [$clog2(LIST_SIZE)-1:0]  val_raddr,
  input  wire logic [VALUE_W-1:0]            val_rdata
);

  localparam int unsigned IW   = $clog2(LIST_SIZE);
  localparam int unsigned CMPW = ((IW > POS_W) ? IW : POS_W) + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(LIST_SIZE - 1);

  seq_state_t state_r, state_nxt;

  logic [IW-1:0]       clr_idx_r, clr_idx_nxt;
  logic [IW-1:0]       free_head_r, free_head_nxt;
  logic [IW-1:0]       cnt_r, cnt_nxt;
  logic [IW-1:0]       prev_r, prev_nxt;
  logic [IW-1:0]       succ_r, succ_nxt;
  logic [IW-1:0]       node_r, node_nxt;
  logic [POS_W-1:0]    walk_cnt_r, walk_cnt_nxt;
  logic [ACTION_W-1:0] act_r, act_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [VALUE_W-1:0]  res_removed_r, res_removed_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]  out_removed_r, out_removed_nxt;
  logic [POS_W-1:0]    out_length_r, out_length_nxt;

  logic                is_full;
  logic                pos_bad;
  logic [STATUS_W-1:0] chk_status;
  logic [CMPW-1:0]     pos_ext;
  logic [CMPW-1:0]     cnt_ext;
  logic                slot_free;

  // admission checks, full store wins over a bad position
  always_comb begin
    pos_ext = CMPW'(in_position);
    cnt_ext = CMPW'(cnt_r);
    is_full = (cnt_r >= LAST_IDX) || (free_head_r == '0);
    if (in_action == ACT_DELETE) begin
      pos_bad = (pos_ext == '0) || (pos_ext > cnt_ext);
    end else begin
      pos_bad = (pos_ext == '0) || (pos_ext > (cnt_ext + CMPW'(1)));
    end
    if ((in_action == ACT_INSERT) && is_full) begin
      chk_status = STAT_FULL;
    end else if (pos_bad) begin
      chk_status = STAT_RANGE;
    end else begin
      chk_status = STAT_DONE;
    end
  end

  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_idx_r == LAST_IDX) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (chk_status == STAT_DONE) ? S_WALK : S_FINISH;
        end
      end
      S_WALK: begin
        if (walk_cnt_r == '0) state_nxt = S_LINK;
      end
      S_LINK:   state_nxt = S_WBACK;
      S_WBACK:  state_nxt = S_FINISH;
      S_FINISH: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    clr_idx_nxt     = clr_idx_r;
    free_head_nxt   = free_head_r;
    cnt_nxt         = cnt_r;
    prev_nxt        = prev_r;
    succ_nxt        = succ_r;
    node_nxt        = node_r;
    walk_cnt_nxt    = walk_cnt_r;
    act_nxt         = act_r;
    val_nxt         = val_r;
    res_status_nxt  = res_status_r;
    res_removed_nxt = res_removed_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_length_nxt  = out_length_r;
    link_we         = 1'b0;
    link_waddr      = '0;
    link_wdata      = '0;
    link_raddr      = '0;
    val_we          = 1'b0;
    val_waddr       = '0;
    val_wdata       = '0;
    val_raddr       = '0;
    in_ready        = 1'b0;

    case (state_r)
      S_CLEAR: begin
        // free chain 1 -> 2 -> ... -> last, head and last end in 0
        link_we    = 1'b1;
        link_waddr = clr_idx_r;
        link_wdata = ((clr_idx_r == '0) || (clr_idx_r == LAST_IDX)) ?
                     '0 : (clr_idx_r + IW'(1));
        clr_idx_nxt = clr_idx_r + IW'(1);
      end
      S_IDLE: begin
        in_ready = 1'b1;
        // head link is fetched in the accept cycle
        link_raddr = '0;
        if (in_valid) begin
          act_nxt         = in_action;
          val_nxt         = in_value_in;
          walk_cnt_nxt    = in_position - POS_W'(1);
          prev_nxt        = '0;
          res_status_nxt  = chk_status;
          res_removed_nxt = '0;
        end
      end
      S_WALK: begin
        // link_rdata is the successor of prev_r
        if (walk_cnt_r != '0) begin
          prev_nxt     = link_rdata;
          link_raddr   = link_rdata;
          walk_cnt_nxt = walk_cnt_r - POS_W'(1);
        end else begin
          succ_nxt   = link_rdata;
          link_raddr = (act_r == ACT_DELETE) ? link_rdata : free_head_r;
        end
      end
      S_LINK: begin
        if (act_r == ACT_DELETE) begin
          // unlink: prev -> successor of the victim
          node_nxt   = succ_r;
          link_we    = 1'b1;
          link_waddr = prev_r;
          link_wdata = link_rdata;
          val_raddr  = succ_r;
        end else begin
          // new node points at the old successor, free chain advances
          node_nxt      = free_head_r;
          free_head_nxt = link_rdata;
          link_we       = 1'b1;
          link_waddr    = free_head_r;
          link_wdata    = succ_r;
          val_we        = 1'b1;
          val_waddr     = free_head_r;
          val_wdata     = val_r;
        end
      end
      S_WBACK: begin
        link_we = 1'b1;
        if (act_r == ACT_DELETE) begin
          link_waddr      = node_r;
          link_wdata      = free_head_r;
          free_head_nxt   = node_r;
          res_removed_nxt = val_rdata;
          cnt_nxt         = cnt_r - IW'(1);
        end else begin
          link_waddr = prev_r;
          link_wdata = node_r;
          cnt_nxt    = cnt_r + IW'(1);
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_removed_nxt = res_removed_r;
          out_length_nxt  = cnt_ext[POS_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      free_head_r <= IW'(1);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      free_head_r <= free_head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r        <= prev_nxt;
    succ_r        <= succ_nxt;
    node_r        <= node_nxt;
    walk_cnt_r    <= walk_cnt_nxt;
    act_r         <= act_nxt;
    val_r         <= val_nxt;
    res_status_r  <= res_status_nxt;
    res_removed_r <= res_removed_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_length_r  <= out_length_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_list_length   = out_length_r;

endmodule

`default_nettype wire

// ===== hw/rtl/static_linked_list_engine_top.sv =====
// top level of the cursor-linked list engine
// depends on slle_pkg, slle_ram and slle_seq
`default_nettype none

// cursor-linked list engine: a singly linked list of bytes kept in a node store
// of LIST_SIZE entries; node 0 is the head, unused nodes sit on a free chain
//
// input channel (in_valid/in_ready): one transfer is one item; in_action 0
// inserts in_value_in at 1-based in_position (1..length+1), 1 deletes the
// element at in_position (1..length)
// result channel (out_valid/out_ready): one transfer per item carrying
// status (done, store full, position out of range), the removed byte on a
// good delete (else 0) and the list length after the item
//
// sequencing: a good item passes the walk, link, write-back and finish states,
// a rejected one goes straight to finish; the link walk reads one link per
// cycle from the registered-read link ram; one item is worked on at a time
//
// reset: after rst_n the link ram is swept once, with in_ready low, to build
// the free chain; the list is then empty
// stall: a finished result waits in the output register while the next item
// may already be accepted; a second result holds in the sequencer until the
// output register drains

module static_linked_list_engine_top
  import slle_pkg::*;
#(
  parameter int unsigned LIST_SIZE = LIST_SIZE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [ACTION_W-1:0] in_action,
  input  wire logic [POS_W-1:0]    in_position,
  input  wire logic [VALUE_W-1:0]  in_value_in,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [STATUS_W-1:0] out_status,
  output      logic [VALUE_W-1:0]  out_removed_value,
  output      logic [POS_W-1:0]    out_list_length
);

  localparam int unsigned IW = $clog2(LIST_SIZE);

  // link ram port
  logic          link_we;
  logic [IW-1:0] link_waddr;
  logic [IW-1:0] link_wdata;
  logic [IW-1:0] link_raddr;
  logic [IW-1:0] link_rdata;

  // value ram port
  logic               val_we;
  logic [IW-1:0]      val_waddr;
  logic [VALUE_W-1:0] val_wdata;
  logic [IW-1:0]      val_raddr;
  logic [VALUE_W-1:0] val_rdata;

  slle_seq #(
    .LIST_SIZE(LIST_SIZE)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_position      (in_position),
    .in_value_in      (in_value_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_list_length  (out_list_length),
    .link_we          (link_we),
    .link_waddr       (link_waddr),
    .link_wdata       (link_wdata),
    .link_raddr       (link_raddr),
    .link_rdata       (link_rdata),
    .val_we           (val_we),
    .val_waddr        (val_waddr),
    .val_wdata        (val_wdata),
    .val_raddr        (val_raddr),
    .val_rdata        (val_rdata)
  );

  // next-link store, built by the clearing pass
  slle_ram #(
    .DEPTH(LIST_SIZE),
    .WIDTH(IW)
  ) u_link_ram (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .raddr(link_raddr),
    .rdata(link_rdata)
  );

  // node bytes, only read back from nodes an insert wrote
  slle_ram #(
    .DEPTH(LIST_SIZE),
    .WIDTH(VALUE_W)
  ) u_val_ram (
    .clk  (clk),
    .we   (val_we),
    .waddr(val_waddr),
    .wdata(val_wdata),
    .raddr(val_raddr),
    .rdata(val_rdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/slle_checker.sv =====
// port-level checks for the cursor-linked list engine, bound to the top level
// depends on slle_pkg and static_linked_list_engine_top
`default_nettype none

module slle_props
  import slle_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [VALUE_W-1:0]  out_removed_value,
  input wire logic [POS_W-1:0]    out_list_length
);

  // the clearing pass keeps the input closed right after reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input open right after reset");

  // one item at a time: busy in the cycle after an input transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input reopened right after a transfer");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) &&
      $stable(out_removed_value) && $stable(out_list_length)))
    else $error("stalled result changed");

  // a rejected item carries no removed byte
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_DONE)) |-> (out_removed_value == '0))
    else $error("rejected item returned a byte");

endmodule

bind static_linked_list_engine_top slle_props u_slle_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_removed_value(out_removed_value),
  .out_list_length  (out_list_length)
);

`default_nettype wire
